/* rtl/ftlu_pkg.sv */
// shared types and codes of the forwarding table lookup and update block
// depends on nothing; used by ftlu_ctrl, ftlu_dp and the top level
package ftlu_pkg;

    localparam int KEY_W  = 16;
    localparam int LINK_W = 8;
    localparam int KIND_W = 2;
    localparam int STS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_UPSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;

    localparam logic [STS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LINK_W-1:0] link;
        logic              vmark;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic hit;
        logic scan_end;
    } t_sts;

endpackage

/* rtl/ftlu_ctrl.sv */
// controller state machine of the forwarding table block
// depends on ftlu_pkg; drives the datapath through t_cmd and reads t_sts
module ftlu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ftlu_pkg::t_sts i_sts,
    output ftlu_pkg::t_cmd o_cmd
);
    import ftlu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    t_cmd   cmd;

    always_comb begin
        n_state      = r_state;
        cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.skip) begin
                    n_state = S_DONE;
                end else begin
                    cmd.scan = 1'b1;
                    if (i_sts.hit || i_sts.scan_end) begin
                        cmd.decide = 1'b1;
                        n_state    = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("result register overwritten while held");

    a_decide_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.decide |=> !cmd.decide && !cmd.scan)
        else $error("scan continued after decision");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !o_in_ready)
        else $error("input ready while item in work");

endmodule

/* rtl/ftlu_dp.sv */
// datapath of the forwarding table: entry memory, scan pointer, compare,
// entry count and result registers; depends on ftlu_pkg
module ftlu_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ftlu_pkg::KIND_W-1:0]   i_kind,
    input  logic [ftlu_pkg::KEY_W-1:0]    i_dest_address,
    input  logic [ftlu_pkg::LINK_W-1:0]   i_link_number,
    input  logic                          i_entry_valid,
    input  ftlu_pkg::t_cmd                i_cmd,
    output ftlu_pkg::t_sts                o_sts,
    output logic [ftlu_pkg::STS_W-1:0]    o_status,
    output logic [ftlu_pkg::LINK_W-1:0]   o_found_link
);
    import ftlu_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_entry            mem [TABLE_DEPTH];
    t_entry            r_rd_data;

    logic [KIND_W-1:0] r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [LINK_W-1:0] r_link;
    logic              r_vmark;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_vld;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [STS_W-1:0]  r_status, n_status;
    logic [LINK_W-1:0] r_flink, n_flink;

    logic              rd_en;
    logic              hit;
    logic              scan_end;
    logic              not_full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;

    assign rd_en    = i_cmd.scan && (r_rd_idx != r_count);
    assign hit      = r_cmp_vld && (r_rd_data.key == r_key);
    assign scan_end = (r_rd_idx == r_count);
    assign not_full = (r_count != CNT_W'(TABLE_DEPTH));

    assign o_sts.skip     = !(r_kind == KIND_UPSERT || r_kind == KIND_LOOKUP ||
                              r_kind == KIND_UPDATE);
    assign o_sts.hit      = hit;
    assign o_sts.scan_end = scan_end;

    always_comb begin
        wr_en         = 1'b0;
        wr_addr       = r_cmp_idx;
        wr_data.key   = r_key;
        wr_data.link  = r_link;
        wr_data.vmark = r_vmark;
        n_count       = r_count;
        n_status      = r_status;
        n_flink       = r_flink;
        if (i_cmd.load) begin
            n_status = ST_OK;
            n_flink  = '0;
        end else if (i_cmd.decide) begin
            if (hit) begin
                if (r_kind == KIND_LOOKUP) begin
                    n_flink = r_rd_data.link;
                end else begin
                    wr_en = 1'b1;
                end
            end else if (r_kind == KIND_UPSERT) begin
                if (not_full) begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[IDX_W-1:0];
                    n_count = r_count + 1'b1;
                end else begin
                    n_status = ST_FULL;
                end
            end else begin
                n_status = ST_MISS;
            end
        end
    end

    // entry memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_key   <= i_dest_address;
            r_link  <= i_link_number;
            r_vmark <= i_entry_valid;
        end
        if (i_cmd.load) begin
            r_rd_idx <= '0;
        end else if (rd_en) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        if (rd_en) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        r_status <= n_status;
        r_flink  <= n_flink;
        if (i_cmd.out_load) begin
            o_status     <= r_status;
            o_found_link <= r_flink;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_cmp_vld <= rd_en;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("entry count decreased");

    a_cmp_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> $past(i_cmd.scan))
        else $error("compare without a scan read");

endmodule

/* rtl/forwarding_table_lookup_update.sv */
// top level of the exact-match forwarding table
// depends on ftlu_pkg, ftlu_ctrl and ftlu_dp
//
// Input channel i_in_valid / o_in_ready carries one request beat: kind
// (upsert, lookup, update), destination address, link number and valid mark.
// Output channel o_out_valid / i_out_ready carries one result beat per
// request: status (ok, not present, full) and found link.
// A request scans the filled entries in order, one memory read a cycle
// through the single read port of the entry memory; the compare of an entry
// lands in the cycle after its read. The scan ends at the first match or
// after the last filled entry; an unused kind skips the scan. The result
// then moves into the output register once that register is free, and
// o_out_valid is registered together with it.
// The block works on one request at a time; o_in_ready is high only between
// requests. A held result does not block the next request, but a finished
// request waits until the output register is free.
// Reset empties the table (entry count zero) and drops any held result.
module forwarding_table_lookup_update #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ftlu_pkg::KIND_W-1:0] i_kind,
    input  logic [ftlu_pkg::KEY_W-1:0]  i_dest_address,
    input  logic [ftlu_pkg::LINK_W-1:0] i_link_number,
    input  logic                        i_entry_valid,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ftlu_pkg::STS_W-1:0]  o_status,
    output logic [ftlu_pkg::LINK_W-1:0] o_found_link
);
    import ftlu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ftlu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ftlu_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_dest_address (i_dest_address),
        .i_link_number  (i_link_number),
        .i_entry_valid  (i_entry_valid),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_status       (o_status),
        .o_found_link   (o_found_link)
    );

endmodule
